@@ sv/adaptive_box_nms_top_defines.svh @@
// assertion macros for the box suppression block
`ifndef ADAPTIVE_BOX_NMS_TOP_DEFINES_SVH
`define ADAPTIVE_BOX_NMS_TOP_DEFINES_SVH
`ifndef SYNTH
`define ABN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ABN_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABN_ASSERT(label, clk, rst, prop, msg)
`define ABN_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ sv/abn_pkg.sv @@
// ----------------------------------------------------------------------------
// abn_pkg
// shared types and constants of the adaptive box suppression block
// ----------------------------------------------------------------------------
package abn_pkg;
   localparam int MAX_KEPT   = 1024;
   localparam int COORD_BITS = 12;
   localparam int IDX_BITS   = $clog2(MAX_KEPT);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int BOX_BITS   = 4 * COORD_BITS;
   localparam int QDEPTH     = 2;

   localparam logic [15:0] THR_BYPASS = 16'd64880;
   localparam logic [15:0] THR_HALF   = 16'd32768;
   localparam logic [16:0] Q_ONE      = 17'd65536;

   localparam logic [1:0] REG_THR   = 2'd0;
   localparam logic [1:0] REG_DECAY = 2'd1;
   localparam logic [1:0] REG_MAX   = 2'd2;

   typedef struct packed {
      logic                  first;
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] wid;
      logic [COORD_BITS-1:0] hgt;
      logic [15:0]           score;
   } item_type;
endpackage

@@ sv/abn_ram.sv @@
// ----------------------------------------------------------------------------
// abn_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module abn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ sv/abn_front.sv @@
// ----------------------------------------------------------------------------
// abn_front
// input beat capture and small queue toward the suppression engine
// ----------------------------------------------------------------------------
module abn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  abn_pkg::item_type in_item,
   output logic              q_valid,
   input  logic              q_pop,
   output abn_pkg::item_type q_item
);
   abn_pkg::item_type buf_ff [abn_pkg::QDEPTH];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push;

   assign in_stall = (cnt_ff == 2'(abn_pkg::QDEPTH));
   assign push     = in_valid && !in_stall;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            buf_ff[wp_ff] <= in_item;
            wp_ff <= wp_ff + 1'b1;
         end
         if (q_pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_pop);
      end
   end
endmodule

@@ sv/abn_back.sv @@
// ----------------------------------------------------------------------------
// abn_back
// sequential compare of one box against each kept box in turn, store and decay
// ----------------------------------------------------------------------------
module abn_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  abn_pkg::item_type q_item,
   input  logic [15:0]       cfg_thr,
   input  logic [16:0]       cfg_decay,
   input  logic [10:0]       cfg_max,
   output logic              out_valid,
   input  logic              out_stall,
   output abn_pkg::item_type out_item,
   output logic              out_kept,
   output logic [10:0]       out_total,
   output logic              busy
);
   localparam int CB = abn_pkg::COORD_BITS;
   localparam int IB = abn_pkg::IDX_BITS;
   localparam int NB = abn_pkg::CNT_BITS;
   localparam int AB = 2 * CB;
   localparam int PB = AB + 17;

   typedef enum logic [3:0] {S_IDLE, S_READ, S_AREA, S_MUL, S_UNI, S_PROD, S_CMP, S_KEEP,
                             S_DONE} state_type;

   state_type             state_ff;
   abn_pkg::item_type     cur_ff;
   logic [NB-1:0]         count_ff;
   logic [15:0]           thr_ff;
   logic [IB-1:0]         idx_ff;
   logic                  keep_ff;
   logic [CB-1:0]         iw_ff, ih_ff;
   logic [AB-1:0]         inter_ff, ia_ff, ib_ff;
   logic [AB:0]           uni_ff;
   logic [PB-1:0]         rhs_ff;
   logic                  empty_ff;
   logic [10:0]           total_ff;

   logic [abn_pkg::BOX_BITS-1:0] rd_data;
   logic [CB-1:0] sc, sr, sw, sh;
   logic          wr_en;
   logic [CB:0]   a0, a1, b0, b1, c0, c1, d0, d1, lox, hix, loy, hiy;
   logic [NB-1:0] cnt_eff, limit;
   logic [15:0]   thr_eff;
   logic [32:0]   dprod;

   assign {sc, sr, sw, sh} = rd_data;
   assign wr_en = (state_ff == S_KEEP);

   abn_ram #(.WIDTH(abn_pkg::BOX_BITS), .DEPTH(abn_pkg::MAX_KEPT)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[IB-1:0]),
      .wr_data({cur_ff.col, cur_ff.row, cur_ff.wid, cur_ff.hgt}),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   // intersection spans
   always_comb begin
      a0 = {1'b0, cur_ff.col};  a1 = a0 + {1'b0, cur_ff.wid};
      b0 = {1'b0, sc};          b1 = b0 + {1'b0, sw};
      c0 = {1'b0, cur_ff.row};  c1 = c0 + {1'b0, cur_ff.hgt};
      d0 = {1'b0, sr};          d1 = d0 + {1'b0, sh};
      lox = (a0 > b0) ? a0 : b0;
      hix = (a1 < b1) ? a1 : b1;
      loy = (c0 > d0) ? c0 : d0;
      hiy = (c1 < d1) ? c1 : d1;
   end

   assign cnt_eff = q_item.first ? '0 : count_ff;
   assign thr_eff = q_item.first ? cfg_thr : thr_ff;
   assign limit   = (cfg_max > 11'(abn_pkg::MAX_KEPT)) ? NB'(abn_pkg::MAX_KEPT)
                                                       : NB'(cfg_max);
   assign dprod   = thr_ff * cfg_decay;
   assign q_pop   = (state_ff == S_IDLE) && q_valid;
   assign busy    = (state_ff != S_IDLE);
   assign out_valid = (state_ff == S_DONE);
   assign out_item  = cur_ff;
   assign out_kept  = keep_ff;
   assign out_total = total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         thr_ff   <= 16'd36045;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff   <= q_item;
                  count_ff <= cnt_eff;
                  thr_ff   <= thr_eff;
                  idx_ff   <= '0;
                  if (thr_eff > abn_pkg::THR_BYPASS) begin
                     keep_ff  <= 1'b1;
                     if (cnt_eff < NB'(abn_pkg::MAX_KEPT)) begin
                        count_ff <= cnt_eff + 1'b1;
                        total_ff <= 11'(cnt_eff + 1'b1);
                     end else begin
                        total_ff <= 11'(cnt_eff);
                     end
                     state_ff <= S_DONE;
                  end else if (cnt_eff >= limit) begin
                     keep_ff  <= 1'b0;
                     total_ff <= 11'(cnt_eff);
                     state_ff <= S_DONE;
                  end else begin
                     keep_ff  <= 1'b1;
                     state_ff <= (cnt_eff == '0) ? S_KEEP : S_READ;
                  end
               end
            end
            S_READ: begin
               // ram read of entry idx_ff lands next cycle
               state_ff <= S_AREA;
            end
            S_AREA: begin
               iw_ff    <= (hix > lox) ? CB'(hix - lox) : '0;
               ih_ff    <= (hiy > loy) ? CB'(hiy - loy) : '0;
               ia_ff    <= cur_ff.wid * cur_ff.hgt;
               ib_ff    <= sw * sh;
               empty_ff <= (cur_ff.wid == '0) || (cur_ff.hgt == '0) ||
                           (sw == '0) || (sh == '0);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               inter_ff <= iw_ff * ih_ff;
               state_ff <= S_UNI;
            end
            S_UNI: begin
               uni_ff   <= ia_ff + ib_ff - inter_ff;
               state_ff <= S_PROD;
            end
            S_PROD: begin
               rhs_ff   <= thr_ff * uni_ff;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               // inter * 1.0 against thr * union, no division
               if (!empty_ff && ({1'b0, inter_ff, 16'd0} > rhs_ff)) begin
                  keep_ff  <= 1'b0;
                  total_ff <= 11'(count_ff);
                  state_ff <= S_DONE;
               end else if (NB'(idx_ff) + 1'b1 < count_ff) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_READ;
               end else begin
                  state_ff <= S_KEEP;
               end
            end
            S_KEEP: begin
               count_ff <= count_ff + 1'b1;
               total_ff <= 11'(count_ff + 1'b1);
               if (cfg_decay < abn_pkg::Q_ONE && thr_ff > abn_pkg::THR_HALF) begin
                  thr_ff <= dprod[31:16];
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!out_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ sv/abn_csr.sv @@
// ----------------------------------------------------------------------------
// abn_csr
// apb register bank for threshold, decay and list limit
// ----------------------------------------------------------------------------
module abn_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [15:0] thr,
   output logic [16:0] decay,
   output logic [10:0] maxk
);
   logic [15:0] thr_ff;
   logic [16:0] decay_ff;
   logic [10:0] max_ff;
   logic [1:0]  sel;

   assign sel    = paddr[3:2];
   assign pready = 1'b1;
   assign thr    = thr_ff;
   assign decay  = decay_ff;
   assign maxk   = max_ff;

   always_comb begin
      case (sel)
         abn_pkg::REG_THR:   prdata = {16'd0, thr_ff};
         abn_pkg::REG_DECAY: prdata = {15'd0, decay_ff};
         abn_pkg::REG_MAX:   prdata = {21'd0, max_ff};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= 16'd36045;
         decay_ff <= 17'd65536;
         max_ff   <= 11'd1000;
      end else if (psel && penable && pwrite) begin
         case (sel)
            abn_pkg::REG_THR:   thr_ff   <= pwdata[15:0];
            abn_pkg::REG_DECAY: decay_ff <= pwdata[16:0];
            abn_pkg::REG_MAX:   max_ff   <= pwdata[10:0];
            default: ;
         endcase
      end
   end
endmodule

@@ sv/adaptive_box_nms_top.sv @@
// a bypassed or over-limit box goes straight to its result; any other box is compared to each
// kept box in turn (read, area, multiply, union, product, compare), ending at the first that
// suppresses it, else in keep, which stores it; one box is in the engine at a time
// the next is popped the cycle after its result is taken; the two-entry queue fills meanwhile
// reset is synchronous: registers reload defaults, kept count clears, store is not cleared
// ----------------------------------------------------------------------------
// adaptive_box_nms_top
// greedy box suppression with adaptive overlap threshold
// ----------------------------------------------------------------------------
`include "adaptive_box_nms_top_defines.svh"
module adaptive_box_nms_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_first_box,
   input  logic [11:0] req_box_col,
   input  logic [11:0] req_box_row,
   input  logic [11:0] req_box_width,
   input  logic [11:0] req_box_height,
   input  logic [15:0] req_box_score,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kept,
   output logic [11:0] rsp_out_col,
   output logic [11:0] rsp_out_row,
   output logic [11:0] rsp_out_width,
   output logic [11:0] rsp_out_height,
   output logic [15:0] rsp_out_score,
   output logic [10:0] rsp_kept_total,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   abn_pkg::item_type in_item, q_item, out_item;
   logic q_valid, q_pop, busy;
   logic [15:0] thr;
   logic [16:0] decay;
   logic [10:0] maxk;

   assign in_item = '{req_first_box, req_box_col, req_box_row, req_box_width,
                      req_box_height, req_box_score};

   abn_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .thr(thr), .decay(decay), .maxk(maxk)
   );

   abn_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_item(in_item),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
   );

   abn_back u_back (
      .clock, .reset, .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
      .cfg_thr(thr), .cfg_decay(decay), .cfg_max(maxk),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_item(out_item),
      .out_kept(rsp_kept), .out_total(rsp_kept_total), .busy(busy)
   );

   assign rsp_out_col    = out_item.col;
   assign rsp_out_row    = out_item.row;
   assign rsp_out_width  = out_item.wid;
   assign rsp_out_height = out_item.hgt;
   assign rsp_out_score  = out_item.score;

   `ABN_ASSERT(a_pop_idle, clock, reset, q_pop |-> !rsp_valid, "pop while result pending")
   `ABN_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped")
   `ABN_ASSERT(a_busy_rsp, clock, reset, rsp_valid |-> busy, "result without busy")
endmodule
